[rtl/lbca_pkg.sv]
// Shared types, constants and helpers for the linked block chain allocator.
// Depends on nothing; every other file but lbca_ram imports it.
`default_nettype none

package lbca_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int TAG_W      = 2;
  localparam int ENTRY_W    = TAG_W + IDX_W;

  // Port field widths
  localparam int BC_W      = 9;
  localparam int LEN_W     = 9;
  localparam int START_W   = 8;
  localparam int STAT_W    = 2;
  localparam int OUT_IDX_W = 8;
  localparam int OUT_CNT_W = 9;

  localparam logic [BC_W-1:0] BC_RESET = BC_W'(256);

  typedef enum logic [TAG_W-1:0] {
    TAG_END  = 2'd1,
    TAG_LINK = 2'd2
  } tag_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_ZERO_LEN = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC,
    S_FREE_WALK,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    cfg_load;
    logic    set_err;
    status_e err_code;
    logic    alloc_init;
    logic    alloc_step;
    logic    alloc_fin;
    logic    free_init;
    logic    free_step;
    logic    out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free_cmd;
    logic zero_len;
    logic no_space;
    logic not_used;
    logic alloc_done;
    logic walk_more;
    logic out_busy;
  } dp_stat_t;

  // Blocks in use: block_count clipped to the table size
  function automatic logic [CNT_W-1:0] blocks_in_use(input logic [BC_W-1:0] bc);
    logic [CNT_W-1:0] n;
    if (int'(bc) > MAX_BLOCKS) n = CNT_W'(MAX_BLOCKS);
    else                       n = CNT_W'(bc);
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/lbca_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lbca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/lbca_ctrl.sv]
// Sequencing state machine: accept, check, scan or walk, deliver.
// Depends on lbca_pkg; drives lbca_dpath through ctrl_cmd_t.
`default_nettype none

module lbca_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire lbca_pkg::dp_stat_t  stat_i,
  output lbca_pkg::ctrl_cmd_t      cmd_o
);

  import lbca_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
        cmd_o.cfg_load = cfg_valid_i;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.is_free_cmd) begin
          if (stat_i.not_used) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ST_NOT_USED;
            state_d        = S_DONE;
          end else begin
            cmd_o.free_init = 1'b1;
            state_d         = S_FREE_WALK;
          end
        end else if (stat_i.zero_len) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = ST_ZERO_LEN;
          state_d        = S_DONE;
        end else if (stat_i.no_space) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = ST_NO_SPACE;
          state_d        = S_DONE;
        end else begin
          cmd_o.alloc_init = 1'b1;
          state_d          = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (stat_i.alloc_done) begin
          cmd_o.alloc_fin = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.alloc_step = 1'b1;
        end
      end
      S_FREE_WALK: begin
        cmd_o.free_step = 1'b1;
        if (!stat_i.walk_more) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the beat
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/lbca_dpath.sv]
// Datapath: link table RAM, per-entry valid bits, counters and output register.
// Depends on lbca_pkg and lbca_ram; steered by lbca_ctrl.
`default_nettype none

module lbca_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire lbca_pkg::ctrl_cmd_t               cmd_i,
  output lbca_pkg::dp_stat_t                     stat_o,
  input  wire logic [lbca_pkg::BC_W-1:0]         block_count_i,
  input  wire logic                              command_i,
  input  wire logic [lbca_pkg::LEN_W-1:0]        length_i,
  input  wire logic [lbca_pkg::START_W-1:0]      start_block_i,
  input  wire logic                              out_stall_i,
  output logic                                   out_valid_o,
  output logic      [lbca_pkg::STAT_W-1:0]       status_o,
  output logic      [lbca_pkg::OUT_IDX_W-1:0]    chain_start_o,
  output logic      [lbca_pkg::OUT_IDX_W-1:0]    chain_end_o,
  output logic      [lbca_pkg::OUT_CNT_W-1:0]    blocks_freed_o,
  output logic      [lbca_pkg::OUT_CNT_W-1:0]    free_left_o
);

  import lbca_pkg::*;

  // Control state
  logic [MAX_BLOCKS-1:0] valid_q;
  logic [BC_W-1:0]       block_count_q;
  logic [CNT_W-1:0]      free_cnt_q;
  logic                  out_valid_q;

  // Working registers
  cmd_e             cmd_q;
  logic [LEN_W-1:0] len_q;
  logic [IDX_W-1:0] start_q;
  logic [CNT_W-1:0] idx_q;
  logic [LEN_W-1:0] left_q;
  logic [IDX_W-1:0] first_q;
  logic [IDX_W-1:0] last_q;
  logic             have_q;
  logic [IDX_W-1:0] cur_q;
  logic [CNT_W-1:0] freed_q;
  status_e          st_q;

  // Output register
  status_e              out_status_q;
  logic [OUT_IDX_W-1:0] out_start_q;
  logic [OUT_IDX_W-1:0] out_end_q;
  logic [OUT_CNT_W-1:0] out_freed_q;
  logic [OUT_CNT_W-1:0] out_left_q;

  logic [CNT_W-1:0]   n;
  logic [IDX_W-1:0]   scan_blk;
  logic               scan_hit;
  logic [ENTRY_W-1:0] rd_entry;
  logic [TAG_W-1:0]   rd_tag;
  logic [IDX_W-1:0]   rd_next;
  logic [CNT_W-1:0]   freed_inc;
  logic               walk_more;
  logic [CNT_W:0]     free_sum;
  logic [CNT_W-1:0]   free_sat;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;

  always_comb begin
    n         = blocks_in_use(block_count_q);
    scan_blk  = idx_q[IDX_W-1:0];
    scan_hit  = !valid_q[scan_blk];
    rd_tag    = rd_entry[ENTRY_W-1 -: TAG_W];
    rd_next   = rd_entry[IDX_W-1:0];
    freed_inc = freed_q + CNT_W'(1);
    // stop before a block that is already free, including the one released now
    walk_more = (rd_tag == TAG_LINK) && ({1'b0, rd_next} < n) && valid_q[rd_next]
                && (rd_next != cur_q) && (freed_inc < n);
    free_sum  = {1'b0, free_cnt_q} + {1'b0, freed_inc};
    free_sat  = (free_sum > {1'b0, n}) ? n : free_sum[CNT_W-1:0];
  end

  always_comb begin
    stat_o.is_free_cmd = (cmd_q == CMD_FREE);
    stat_o.zero_len    = (len_q == '0);
    stat_o.no_space    = (int'(len_q) > int'(free_cnt_q));
    stat_o.not_used    = ({1'b0, start_q} >= n) || !valid_q[start_q];
    stat_o.alloc_done  = (idx_q >= n) || (left_q == '0);
    stat_o.walk_more   = walk_more;
    stat_o.out_busy    = out_valid_q && out_stall_i;
  end

  // Link table port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = last_q;
    ram_wdata = {TAG_END, {IDX_W{1'b0}}};
    ram_re    = 1'b0;
    ram_raddr = start_q;
    if (cmd_i.alloc_step && scan_hit && have_q) begin
      ram_we    = 1'b1;
      ram_wdata = {TAG_LINK, scan_blk};
    end else if (cmd_i.alloc_fin && have_q) begin
      ram_we = 1'b1;
    end
    if (cmd_i.free_init) begin
      ram_re = 1'b1;
    end else if (cmd_i.free_step && walk_more) begin
      ram_re    = 1'b1;
      ram_raddr = rd_next;
    end
  end

  lbca_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_BLOCKS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      block_count_q <= BC_RESET;
      free_cnt_q    <= blocks_in_use(BC_RESET);
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.cfg_load) begin
        valid_q       <= '0;
        block_count_q <= block_count_i;
        free_cnt_q    <= blocks_in_use(block_count_i);
      end
      if (cmd_i.alloc_step && scan_hit) begin
        valid_q[scan_blk] <= 1'b1;
      end
      if (cmd_i.alloc_fin) begin
        free_cnt_q <= free_cnt_q - CNT_W'(len_q);
      end
      if (cmd_i.free_step) begin
        valid_q[cur_q] <= 1'b0;
        if (!walk_more) begin
          free_cnt_q <= free_sat;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q   <= cmd_e'(command_i);
      len_q   <= length_i;
      start_q <= IDX_W'(start_block_i);
    end
    if (cmd_i.set_err) begin
      st_q <= cmd_i.err_code;
    end
    if (cmd_i.alloc_init) begin
      st_q    <= ST_OK;
      idx_q   <= '0;
      left_q  <= len_q;
      have_q  <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
    end
    if (cmd_i.alloc_step) begin
      idx_q <= idx_q + CNT_W'(1);
      if (scan_hit) begin
        left_q <= left_q - LEN_W'(1);
        last_q <= scan_blk;
        have_q <= 1'b1;
        if (!have_q) begin
          first_q <= scan_blk;
        end
      end
    end
    if (cmd_i.free_init) begin
      st_q    <= ST_OK;
      cur_q   <= start_q;
      freed_q <= '0;
    end
    if (cmd_i.free_step) begin
      freed_q <= freed_inc;
      cur_q   <= rd_next;
    end
    if (cmd_i.out_load) begin
      out_status_q <= st_q;
      out_left_q   <= OUT_CNT_W'(free_cnt_q);
      if (st_q == ST_OK && cmd_q == CMD_ALLOC) begin
        out_start_q <= OUT_IDX_W'(first_q);
        out_end_q   <= OUT_IDX_W'(last_q);
      end else begin
        out_start_q <= '0;
        out_end_q   <= '0;
      end
      if (st_q == ST_OK && cmd_q == CMD_FREE) begin
        out_freed_q <= OUT_CNT_W'(freed_q);
      end else begin
        out_freed_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign chain_start_o  = out_start_q;
  assign chain_end_o    = out_end_q;
  assign blocks_freed_o = out_freed_q;
  assign free_left_o    = out_left_q;

endmodule

`default_nettype wire

[rtl/linked_block_chain_allocator.sv]
// Top level of the linked block chain allocator: controller plus datapath.
// Depends on lbca_pkg, lbca_ctrl, lbca_dpath (and lbca_ram through it).
//
//   channel | handshake                 | payload
//   --------+---------------------------+----------------------------------------
//   in      | in_valid_i / in_stall_o   | command_i, length_i, start_block_i
//   out     | out_valid_o / out_stall_i | status_o, chain_start_o, chain_end_o,
//           |                           | blocks_freed_o, free_left_o
//   cfg     | cfg_valid_i / cfg_ready_o | block_count_i
//
// One command at a time. Allocate scans the blocks in use from block 0 up: the
// free scan visits one table entry per cycle. Free walks the chain: each link
// costs one registered read of the link RAM. Rejected commands go straight
// from the check to the result.
// Reset and a block_count write mark every block free at once through the
// per-entry valid bits; no clearing pass. A stalled result sits in the output
// register; the block then waits with its next result until the beat goes out.
`default_nettype none

module linked_block_chain_allocator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              command_i,
  input  wire logic [lbca_pkg::LEN_W-1:0]        length_i,
  input  wire logic [lbca_pkg::START_W-1:0]      start_block_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [lbca_pkg::STAT_W-1:0]       status_o,
  output logic      [lbca_pkg::OUT_IDX_W-1:0]    chain_start_o,
  output logic      [lbca_pkg::OUT_IDX_W-1:0]    chain_end_o,
  output logic      [lbca_pkg::OUT_CNT_W-1:0]    blocks_freed_o,
  output logic      [lbca_pkg::OUT_CNT_W-1:0]    free_left_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lbca_pkg::BC_W-1:0]         block_count_i
);

  import lbca_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  lbca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  lbca_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .stat_o        (dp_stat),
    .block_count_i (block_count_i),
    .command_i     (command_i),
    .length_i      (length_i),
    .start_block_i (start_block_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .chain_start_o (chain_start_o),
    .chain_end_o   (chain_end_o),
    .blocks_freed_o(blocks_freed_o),
    .free_left_o   (free_left_o)
  );

endmodule

`default_nettype wire

[rtl/lbca_chk.sv]
// Port-level assertions for linked_block_chain_allocator, bound to the top level.
// Depends on lbca_pkg.
`default_nettype none

module lbca_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [lbca_pkg::STAT_W-1:0]       status_o,
  input wire logic [lbca_pkg::OUT_IDX_W-1:0]    chain_start_o,
  input wire logic [lbca_pkg::OUT_IDX_W-1:0]    chain_end_o,
  input wire logic [lbca_pkg::OUT_CNT_W-1:0]    blocks_freed_o,
  input wire logic [lbca_pkg::OUT_CNT_W-1:0]    free_left_o
);

  import lbca_pkg::*;

  // one command at a time: an accepted beat blocks the next
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a command is in flight");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (chain_start_o == '0 && chain_end_o == '0 && blocks_freed_o == '0))
    else $error("rejected command carries chain data");

  a_chain_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |-> (chain_start_o <= chain_end_o))
    else $error("chain end below chain start");

  a_free_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(free_left_o) <= MAX_BLOCKS))
    else $error("free count above table size");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(free_left_o)
       && $stable(chain_start_o) && $stable(chain_end_o) && $stable(blocks_freed_o)))
    else $error("stalled result changed");

endmodule

bind linked_block_chain_allocator lbca_chk u_lbca_chk (.*);

`default_nettype wire

[dv/lbca_checker.sv]
`timescale 1ns / 1ps
// Checker for the linked block chain allocator: keeps its own link table,
// predicts every result from the accepted commands and compares it field by field.
// Depends on lbca_pkg for widths, status codes, command codes and link tags.

module lbca_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_o,
  input  wire logic                          command_i,
  input  wire logic [lbca_pkg::LEN_W-1:0]    length_i,
  input  wire logic [lbca_pkg::START_W-1:0]  start_block_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  input  wire logic [lbca_pkg::STAT_W-1:0]   status_o,
  input  wire logic [lbca_pkg::OUT_IDX_W-1:0] chain_start_o,
  input  wire logic [lbca_pkg::OUT_IDX_W-1:0] chain_end_o,
  input  wire logic [lbca_pkg::OUT_CNT_W-1:0] blocks_freed_o,
  input  wire logic [lbca_pkg::OUT_CNT_W-1:0] free_left_o,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_o,
  input  wire logic [lbca_pkg::BC_W-1:0]     block_count_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o,
  output logic [lbca_pkg::START_W-1:0]       chain_hint_o
);
  import lbca_pkg::*;

  localparam logic [TAG_W-1:0] SLOT_FREE = '0;

  typedef struct packed {
    status_e               status;
    logic [OUT_IDX_W-1:0]  first;
    logic [OUT_IDX_W-1:0]  last;
    logic [OUT_CNT_W-1:0]  freed;
    logic [OUT_CNT_W-1:0]  left;
  } outcome_t;

  logic [TAG_W-1:0] link_tag  [MAX_BLOCKS];
  int               link_next [MAX_BLOCKS];
  logic [BC_W-1:0]  block_count_q;
  int               spare_total;
  outcome_t         expected_outcomes [$];

  function automatic int usable_blocks();
    return (int'(block_count_q) > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count_q);
  endfunction

  function automatic void wipe_links();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      link_tag[i]  = SLOT_FREE;
      link_next[i] = 0;
    end
    spare_total = usable_blocks();
  endfunction

  function automatic outcome_t predict_outcome(input logic cmd,
                                               input logic [LEN_W-1:0] len,
                                               input logic [START_W-1:0] start);
    outcome_t         o;
    int               n;
    int               need;
    int               last_idx;
    int               cur;
    int               nx;
    int               freed;
    logic [TAG_W-1:0] tg;
    bit               have;
    n = usable_blocks();
    o = '0;
    o.status = ST_OK;
    if (cmd == CMD_ALLOC) begin
      if (len == '0) begin
        o.status = ST_ZERO_LEN;
      end else if (int'(len) > spare_total) begin
        o.status = ST_NO_SPACE;
      end else begin
        need = int'(len);
        have = 1'b0;
        last_idx = 0;
        // link the lowest free blocks in ascending order
        for (int i = 0; i < n && need != 0; i++) begin
          if (link_tag[i] != SLOT_FREE) continue;
          if (have) begin
            link_tag[last_idx]  = TAG_LINK;
            link_next[last_idx] = i;
          end else begin
            o.first = OUT_IDX_W'(i);
            have = 1'b1;
          end
          link_tag[i]  = TAG_END;
          link_next[i] = 0;
          last_idx = i;
          need--;
        end
        o.last = OUT_IDX_W'(last_idx);
        spare_total -= int'(len);
        chain_hint_o = o.first;
      end
    end else begin
      if (int'(start) >= n || link_tag[start] == SLOT_FREE) begin
        o.status = ST_NOT_USED;
      end else begin
        cur = int'(start);
        freed = 0;
        // stop before a block already free, so a broken chain ends cleanly
        while (freed < n) begin
          tg = link_tag[cur];
          nx = link_next[cur];
          link_tag[cur]  = SLOT_FREE;
          link_next[cur] = 0;
          freed++;
          if (tg != TAG_LINK || nx >= n || link_tag[nx] == SLOT_FREE) break;
          cur = nx;
        end
        spare_total += freed;
        if (spare_total > n) spare_total = n;
        o.freed = OUT_CNT_W'(freed);
      end
    end
    o.left = OUT_CNT_W'(spare_total);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      block_count_q = BC_RESET;
      wipe_links();
      expected_outcomes.delete();
      fail_count_o = 0;
      checked_o    = 0;
      chain_hint_o = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        block_count_q = block_count_i;
        wipe_links();
      end
      if (out_valid_o && !out_stall_i) begin
        got.status = status_e'(status_o);
        got.first  = chain_start_o;
        got.last   = chain_end_o;
        got.freed  = blocks_freed_o;
        got.left   = free_left_o;
        checked_o++;
        if (expected_outcomes.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("result beat %0d arrived with nothing outstanding", checked_o);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"result beat %0d: status %0d/%0d start %0d/%0d end %0d/%0d ",
                        "freed %0d/%0d left %0d/%0d (expected/actual)"},
                       checked_o, want.status, got.status, want.first, got.first,
                       want.last, got.last, want.freed, got.freed, want.left, got.left);
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        expected_outcomes.push_back(predict_outcome(command_i, length_i, start_block_i));
    end
    pending_o = expected_outcomes.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, command and result traffic,
// block_count writes and the verdict. Depends on lbca_pkg, the block and lbca_checker.

module tb;
  import lbca_pkg::*;

  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int N_PHASES         = 12;
  localparam int ITEMS_PER_PHASE  = 160;
  localparam int HOLD_CYCLES      = 1500;
  localparam int DRAIN_CYCLES     = 300;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 command_i     = 1'b0;
  logic [LEN_W-1:0]     length_i      = '0;
  logic [START_W-1:0]   start_block_i = '0;
  logic                 out_stall_i   = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic [BC_W-1:0]      block_count_i = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [STAT_W-1:0]    status_o;
  logic [OUT_IDX_W-1:0] chain_start_o;
  logic [OUT_IDX_W-1:0] chain_end_o;
  logic [OUT_CNT_W-1:0] blocks_freed_o;
  logic [OUT_CNT_W-1:0] free_left_o;
  logic                 cfg_ready_o;

  int                   fail_count;
  int                   pending;
  int                   checked;
  logic [START_W-1:0]   chain_hint;

  int                   snd_idle_pct = 0;
  int                   rcv_idle_pct = 0;
  int                   hold_requests = 0;
  int                   cycle_count = 0;
  int                   allocs_sent = 0;
  int                   frees_sent = 0;
  int                   settings_written = 0;

  linked_block_chain_allocator u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .command_i, .length_i, .start_block_i,
    .out_valid_o, .out_stall_i, .status_o, .chain_start_o, .chain_end_o,
    .blocks_freed_o, .free_left_o,
    .cfg_valid_i, .cfg_ready_o, .block_count_i
  );

  lbca_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .command_i, .length_i, .start_block_i,
    .out_valid_o, .out_stall_i, .status_o, .chain_start_o, .chain_end_o,
    .blocks_freed_o, .free_left_o,
    .cfg_valid_i, .cfg_ready_o, .block_count_i,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .chain_hint_o (chain_hint)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("linked_block_chain_allocator verification failed");
      $finish;
    end
  end

  // Result side: random stall, or a long hold-off when one is requested
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (holds_done < hold_requests) begin
        holds_done++;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat
  task automatic put_cmd(input logic cmd, input logic [LEN_W-1:0] len,
                         input logic [START_W-1:0] start);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    length_i      <= len;
    start_block_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (cmd == CMD_ALLOC) allocs_sent++;
    else frees_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_block_count(input logic [BC_W-1:0] value);
    drain();
    cfg_valid_i   <= 1'b1;
    block_count_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_written++;
  endtask

  task automatic random_cmd(input int n);
    int               r;
    int               hi;
    logic [LEN_W-1:0] len;
    logic [START_W-1:0] start;
    r = $urandom_range(99);
    len = LEN_W'($urandom_range(511));
    start = START_W'($urandom_range(255));
    if (r < 5) begin
      put_cmd(1'($urandom_range(1)), len, start);
    end else if (r < 55) begin
      hi = (n > 4) ? n / 4 : 1;
      case ($urandom_range(9))
        0:       len = '0;
        1:       len = LEN_W'($urandom_range(511, n + 1));
        default: len = LEN_W'($urandom_range(hi, 1));
      endcase
      put_cmd(CMD_ALLOC, len, start);
    end else begin
      // mostly blocks in use, sometimes the head of the newest chain
      if ($urandom_range(99) < 35) start = chain_hint;
      else if ($urandom_range(99) < 90) start = START_W'($urandom_range(n - 1, 0));
      put_cmd(CMD_FREE, len, start);
    end
  endtask

  initial begin
    logic [BC_W-1:0] phase_counts [N_PHASES];
    int              n;
    phase_counts = '{9'd16, 9'd1, 9'd256, 9'd2, 9'd37, 9'd511,
                     9'd8, 9'd12, 9'd100, 9'd4, 9'd23, 9'd255};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: error codes, mid-chain and broken-chain frees, size extremes
    put_cmd(CMD_FREE,  9'd0,   8'd0);
    put_cmd(CMD_ALLOC, 9'd0,   8'd255);
    put_cmd(CMD_ALLOC, 9'd257, 8'd0);
    put_cmd(CMD_ALLOC, 9'd511, 8'd0);
    put_cmd(CMD_ALLOC, 9'd1,   8'd0);
    put_cmd(CMD_ALLOC, 9'd3,   8'd0);
    put_cmd(CMD_ALLOC, 9'd4,   8'd0);
    put_cmd(CMD_FREE,  9'd511, 8'd2);
    put_cmd(CMD_FREE,  9'd0,   8'd1);
    put_cmd(CMD_ALLOC, 9'd2,   8'd0);
    put_cmd(CMD_FREE,  9'd0,   8'd255);
    put_cmd(CMD_ALLOC, 9'd248, 8'd170);
    put_cmd(CMD_ALLOC, 9'd1,   8'd0);
    put_cmd(CMD_FREE,  9'd0,   8'd4);
    put_cmd(CMD_FREE,  9'd0,   8'd0);
    set_block_count(9'd0);
    put_cmd(CMD_ALLOC, 9'd1,   8'd0);
    put_cmd(CMD_ALLOC, 9'd0,   8'd0);
    put_cmd(CMD_FREE,  9'd0,   8'd0);
    set_block_count(9'd1);
    put_cmd(CMD_ALLOC, 9'd1,   8'd0);
    put_cmd(CMD_ALLOC, 9'd1,   8'd0);
    put_cmd(CMD_FREE,  9'd0,   8'd0);
    set_block_count(9'd511);
    put_cmd(CMD_ALLOC, 9'd256, 8'd0);
    put_cmd(CMD_FREE,  9'd0,   8'd128);
    put_cmd(CMD_FREE,  9'd0,   8'd0);

    for (int p = 0; p < N_PHASES; p++) begin
      set_block_count(phase_counts[p]);
      n = (int'(phase_counts[p]) > MAX_BLOCKS) ? MAX_BLOCKS : int'(phase_counts[p]);
      if (p < N_PHASES / 3) begin
        snd_idle_pct = 9;
        rcv_idle_pct = 60;
      end else if (p < 2 * N_PHASES / 3) begin
        snd_idle_pct = 60;
        rcv_idle_pct = 9;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // back-pressure the result side while commands keep coming; drain once in phase 5
        if (p == 1 && i == 40) hold_requests++;
        if (p == 5 && i == 80) drain();
        random_cmd(n);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d allocates and %0d frees sent over %0d block_count settings",
             allocs_sent, frees_sent, settings_written);
    $display("%0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("linked_block_chain_allocator verification clean");
    end else begin
      $display("linked_block_chain_allocator verification failed");
    end
    $finish;
  end

endmodule
